@@ design/sata_pkg.sv @@
// Shared types, widths and constants for the shadow atlas tile allocator.
package sata_pkg;

    // Field widths of the request and tile words.
    localparam int COUNT_W = 6;
    localparam int COORD_W = 15;
    localparam int SIDE_W  = 16;
    localparam int LOG2_W  = 4;

    // Largest supported atlas side, as log2 of texels.
    localparam int MAX_SIDE_LOG2_DEF = 15;

    // Atlas side log2 after reset.
    localparam logic [LOG2_W-1:0] SIDE_LOG2_RESET = 4'd12;

    // Number of request commands queued between front and back.
    localparam int CMD_QUEUE_DEPTH = 2;

    // Counts at or below this are served by the final split.
    localparam logic [COUNT_W-1:0] FINAL_SPLIT_MAX = 6'd4;

    // Tiles handed out per intermediate split.
    localparam logic [COUNT_W-1:0] TILES_PER_SPLIT = 6'd3;

    // What the back end has to do for one request.
    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_ERROR,
        CMD_SPLIT
    } sata_cmd_kind_t;

    // One classified request.
    typedef struct packed {
        sata_cmd_kind_t      kind;
        logic [COUNT_W-1:0]  count;
        logic [LOG2_W-1:0]   side_log2;
    } sata_cmd_t;

    // Back end sequencer states.
    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } sata_back_state_t;

endpackage

@@ design/sata_req_if.sv @@
// Request channel: one tile count per word.
interface sata_req_if;
    logic                          valid;
    logic                          ready;
    logic [sata_pkg::COUNT_W-1:0]  tile_count;

    modport source (output valid, output tile_count, input ready);
    modport sink (input valid, input tile_count, output ready);
endinterface

@@ design/sata_tile_if.sv @@
// Tile channel: one placed tile per word.
interface sata_tile_if;
    logic                          valid;
    logic                          ready;
    logic [sata_pkg::COORD_W-1:0]  tile_x;
    logic [sata_pkg::COORD_W-1:0]  tile_y;
    logic [sata_pkg::SIDE_W-1:0]   tile_side;
    logic                          last_tile;
    logic                          too_many;

    modport source (output valid, output tile_x, output tile_y, output tile_side,
                    output last_tile, output too_many, input ready);
    modport sink (input valid, input tile_x, input tile_y, input tile_side,
                  input last_tile, input too_many, output ready);
endinterface

@@ design/sata_front.sv @@
// Front end: accepts request words and classifies them into back end commands.
module sata_front #(
    parameter int MAX_SIDE_LOG2 = sata_pkg::MAX_SIDE_LOG2_DEF
) (
    sata_req_if.sink                   req,
    input  logic [sata_pkg::LOG2_W-1:0] atlas_side_log2,
    input  logic                        cmd_full,
    output logic                        cmd_push,
    output sata_pkg::sata_cmd_t         cmd_data
);

    logic [sata_pkg::LOG2_W-1:0]  side_log2;
    logic [sata_pkg::COUNT_W-1:0] split_limit;
    logic                         accept;

    // Clamp the configured side to the supported maximum.
    assign side_log2 = (atlas_side_log2 > sata_pkg::LOG2_W'(MAX_SIDE_LOG2))
                       ? sata_pkg::LOG2_W'(MAX_SIDE_LOG2) : atlas_side_log2;

    // A depth of d splits places at most 3*d+1 tiles, so the largest
    // count that fits is 3*log2(side)+1.
    assign split_limit = (sata_pkg::COUNT_W'(side_log2) << 1)
                         + sata_pkg::COUNT_W'(side_log2) + sata_pkg::COUNT_W'(1);

    assign req.ready = !cmd_full;
    assign accept    = req.valid && req.ready;

    // A zero count produces nothing, so it is dropped here.
    assign cmd_push = accept && (req.tile_count != '0);

    // Classify the request.
    always_comb
    begin
        cmd_data.count     = req.tile_count;
        cmd_data.side_log2 = side_log2;
        if (req.tile_count == sata_pkg::COUNT_W'(1))
        begin
            cmd_data.kind = sata_pkg::CMD_SINGLE;
        end
        else if (req.tile_count > split_limit)
        begin
            cmd_data.kind = sata_pkg::CMD_ERROR;
        end
        else
        begin
            cmd_data.kind = sata_pkg::CMD_SPLIT;
        end
    end

endmodule

@@ design/sata_cmd_queue.sv @@
// Short command queue between the front end and the back end.
module sata_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sata_pkg::sata_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output sata_pkg::sata_cmd_t pop_data,
    output logic                empty
);

    localparam int DEPTH   = sata_pkg::CMD_QUEUE_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    sata_pkg::sata_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [COUNT_W-1:0]  fill_reg;
    logic [COUNT_W-1:0]  fill_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (fill_reg == COUNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= COUNT_W'(DEPTH))
        else $error("command queue overfilled");

endmodule

@@ design/sata_back.sv @@
// Back end: walks the split sequence of one command and emits one tile per cycle while the tile channel is not stalled.
module sata_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  sata_pkg::sata_cmd_t cmd_data,
    output logic                cmd_pop,
    sata_tile_if.source         tile
);

    localparam int COORD_W = sata_pkg::COORD_W;
    localparam int SIDE_W  = sata_pkg::SIDE_W;
    localparam int COUNT_W = sata_pkg::COUNT_W;

    sata_pkg::sata_back_state_t state_reg;
    sata_pkg::sata_back_state_t state_next;
    sata_pkg::sata_cmd_kind_t   kind_reg;
    sata_pkg::sata_cmd_kind_t   kind_next;
    logic [COUNT_W-1:0]         rem_reg;
    logic [COUNT_W-1:0]         rem_next;
    logic [COORD_W-1:0]         org_reg;
    logic [COORD_W-1:0]         org_next;
    logic [SIDE_W-1:0]          side_reg;
    logic [SIDE_W-1:0]          side_next;
    logic [1:0]                 quad_reg;
    logic [1:0]                 quad_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COORD_W-1:0]         out_x_reg;
    logic [COORD_W-1:0]         out_x_next;
    logic [COORD_W-1:0]         out_y_reg;
    logic [COORD_W-1:0]         out_y_next;
    logic [SIDE_W-1:0]          out_side_reg;
    logic [SIDE_W-1:0]          out_side_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic                       out_err_reg;
    logic                       out_err_next;

    logic                       load;
    logic [COORD_W-1:0]         half;
    logic                       final_split;
    logic                       split_last;

    // Quadrant size of the current square; the side is at least two in a split.
    assign half        = side_reg[SIDE_W-1:1];
    assign final_split = (rem_reg <= sata_pkg::FINAL_SPLIT_MAX);
    assign split_last  = final_split && (quad_reg == 2'(rem_reg - COUNT_W'(1)));

    // Sequencer: next state and next tile word.
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        rem_next       = rem_reg;
        org_next       = org_reg;
        side_next      = side_reg;
        quad_next      = quad_reg;
        cmd_pop        = 1'b0;
        load           = 1'b0;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_side_next  = out_side_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        case (state_reg)
            sata_pkg::BACK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    kind_next  = cmd_data.kind;
                    rem_next   = cmd_data.count;
                    org_next   = '0;
                    side_next  = SIDE_W'(1) << cmd_data.side_log2;
                    quad_next  = '0;
                    state_next = sata_pkg::BACK_EMIT;
                end
            end
            sata_pkg::BACK_EMIT:
            begin
                if (!out_valid_reg || tile.ready)
                begin
                    load = 1'b1;
                    case (kind_reg)
                        sata_pkg::CMD_SINGLE:
                        begin
                            out_x_next    = '0;
                            out_y_next    = '0;
                            out_side_next = side_reg;
                            out_last_next = 1'b1;
                            out_err_next  = 1'b0;
                            state_next    = sata_pkg::BACK_IDLE;
                        end
                        sata_pkg::CMD_SPLIT:
                        begin
                            out_x_next    = org_reg + (quad_reg[0] ? half : '0);
                            out_y_next    = org_reg + (quad_reg[1] ? half : '0);
                            out_side_next = SIDE_W'(half);
                            out_last_next = split_last;
                            out_err_next  = 1'b0;
                            if (split_last)
                            begin
                                state_next = sata_pkg::BACK_IDLE;
                            end
                            else if (!final_split && (quad_reg == 2'd2))
                            begin
                                // Bottom-right quadrant becomes the next square.
                                rem_next  = rem_reg - sata_pkg::TILES_PER_SPLIT;
                                org_next  = org_reg + half;
                                side_next = side_reg >> 1;
                                quad_next = '0;
                            end
                            else
                            begin
                                quad_next = quad_reg + 2'd1;
                            end
                        end
                        default:
                        begin
                            // Request too large for the atlas.
                            out_x_next    = '0;
                            out_y_next    = '0;
                            out_side_next = '0;
                            out_last_next = 1'b1;
                            out_err_next  = 1'b1;
                            state_next    = sata_pkg::BACK_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = sata_pkg::BACK_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, cleared once taken.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (tile.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sata_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk registers and tile word need no reset.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        rem_reg      <= rem_next;
        org_reg      <= org_next;
        side_reg     <= side_next;
        quad_reg     <= quad_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_side_reg <= out_side_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign tile.valid     = out_valid_reg;
    assign tile.tile_x    = out_x_reg;
    assign tile.tile_y    = out_y_reg;
    assign tile.tile_side = out_side_reg;
    assign tile.last_tile = out_last_reg;
    assign tile.too_many  = out_err_reg;

    // An error word is always the last of its request and carries no tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_last_reg && out_side_reg == '0))
        else $error("error word without last mark or with a tile");

    // The bottom-right quadrant is only handed out by a final split of four.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sata_pkg::BACK_EMIT && kind_reg == sata_pkg::CMD_SPLIT
         && quad_reg == 2'd3) |-> (rem_reg == sata_pkg::FINAL_SPLIT_MAX))
        else $error("fourth quadrant outside final split");

    // A split never works on a square smaller than two texels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sata_pkg::BACK_EMIT && kind_reg == sata_pkg::CMD_SPLIT)
        |-> (half != '0))
        else $error("split below one texel");

endmodule

@@ design/shadow_atlas_tile_allocator_core.sv @@
// Top level of the shadow atlas tile allocator.
//
// A request word on req carries a tile count; the block answers on tile with
// that many square tiles of an atlas whose side is 2^atlas_side_log2 texels,
// the last one marked by last_tile. A count of zero gives no word at all. A
// count the atlas cannot hold gives one word with too_many set, zero fields.
// The side log2 register is written through cfg_wr_en / cfg_wr_data, by the user
// only while no request is in flight, unchecked by the block. Reset loads 12.
//
// The front end classifies a request in the cycle it is accepted and queues
// it (two commands deep). The back end picks up a command in its idle state,
// then emits one tile per cycle from its output register while the tile
// channel is not stalled, and returns to idle after the last tile. A request
// passes the command queue, the idle state and the emit state before its first
// tile is valid. The walk through the split levels goes one quadrant per cycle.
// A stalled tile channel holds the output word and freezes the walk; requests
// are still taken until the command queue is full.
// Reset empties the queue, drops any word in the output register and returns
// the back end to idle.
module shadow_atlas_tile_allocator_core #(
    parameter int MAX_SIDE_LOG2 = sata_pkg::MAX_SIDE_LOG2_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sata_pkg::LOG2_W-1:0] cfg_wr_data,
    sata_req_if.sink                    req,
    sata_tile_if.source                 tile
);

    logic [sata_pkg::LOG2_W-1:0] atlas_side_log2_reg;
    logic [sata_pkg::LOG2_W-1:0] atlas_side_log2_next;
    logic                        cmd_push;
    logic                        cmd_pop;
    logic                        cmd_full;
    logic                        cmd_empty;
    sata_pkg::sata_cmd_t         cmd_in;
    sata_pkg::sata_cmd_t         cmd_out;

    // Configuration register.
    assign atlas_side_log2_next = cfg_wr_en ? cfg_wr_data : atlas_side_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_side_log2_reg <= sata_pkg::SIDE_LOG2_RESET;
        end
        else
        begin
            atlas_side_log2_reg <= atlas_side_log2_next;
        end
    end

    // Request classification.
    sata_front #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_front (
        .req             (req),
        .atlas_side_log2 (atlas_side_log2_reg),
        .cmd_full        (cmd_full),
        .cmd_push        (cmd_push),
        .cmd_data        (cmd_in)
    );

    // Command queue between the two halves.
    sata_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    // Tile sequencer.
    sata_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .tile      (tile)
    );

endmodule
